// ----- rtl/core/wfsa_pkg.sv -----
package wfsa_pkg;

   // Width of offsets and sizes inside the chunk.
   localparam int AW = 28;
   localparam int FLAGS_W = 9;
   localparam int PRIO_W = 32;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int FREE_SLOTS_DEF = 64;

   localparam logic [AW-1:0] CHUNK_SIZE_RST = AW'(134217728);

   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_FIT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_FLAGS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_PRIO = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   // Control broadcast to every cell of the slice chain.
   typedef struct packed {
      logic          shift;
      logic          wr_en;
      logic [AW-1:0] wr_start;
      logic [AW-1:0] wr_size;
   } cell_ctl_type;

endpackage

// ----- rtl/core/wfsa_channels.sv -----
interface wfsa_req_if;
   import wfsa_pkg::*;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [FLAGS_W-1:0] req_flags;
   logic [PRIO_W-1:0]  req_priority;
   logic [AW-1:0]      req_size;
   logic [AW-1:0]      req_align;
   logic [AW-1:0]      rel_offset;
   logic [AW-1:0]      rel_length;

   modport source (output valid, opcode, req_flags, req_priority, req_size, req_align,
                   rel_offset, rel_length, input ready);
   modport sink (input valid, opcode, req_flags, req_priority, req_size, req_align,
                 rel_offset, rel_length, output ready);
endinterface

interface wfsa_rsp_if;
   import wfsa_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [AW-1:0]       out_offset;
   logic [AW-1:0]       out_length;

   modport source (output valid, status, out_offset, out_length, input ready);
   modport sink (input valid, status, out_offset, out_length, output ready);
endinterface

// ----- rtl/core/wfsa_cell.sv -----
module wfsa_cell import wfsa_pkg::*; #(
   parameter int IW = 6,
   parameter int IDX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  logic [IW-1:0] wr_idx,
   input  logic [AW-1:0] nxt_start,
   input  logic [AW-1:0] nxt_size,
   output logic [AW-1:0] start,
   output logic [AW-1:0] size
);

   logic [AW-1:0] start_ff, start_in;
   logic [AW-1:0] size_ff, size_in;

   always_comb begin
      start_in = start_ff;
      size_in = size_ff;
      if (ctl.wr_en && wr_idx == IW'(IDX)) begin
         start_in = ctl.wr_start;
         size_in = ctl.wr_size;
      end else if (ctl.shift) begin
         start_in = nxt_start;
         size_in = nxt_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         size_ff <= CHUNK_SIZE_RST;
      end else begin
         start_ff <= start_in;
         size_ff <= size_in;
      end
   end

   assign start = start_ff;
   assign size = size_ff;

endmodule

// ----- rtl/core/worst_fit_slice_allocator.sv -----
// Channel  Dir  Handshake          Payload
// req_ch   in   valid/ready        opcode, flags, priority, size, align, offset, length
// rsp_ch   out  valid/ready        status, out_offset, out_length
// csr_*    in   write enable only  index, write data
//
// One word is processed at a time. Each pass of the slice chain rotates the list
// once, one slice per cycle. An allocate makes a find pass and then a remove pass;
// a free makes a merge pass (none with an empty list), after a precheck pass with
// a full list. A rejected word skips the remaining passes. The block then idles.
// Synchronous reset leaves one free slice covering the whole chunk.
// A result waits in the output register while a new word is accepted; the block
// stalls only when a second result is ready before the first one is taken.
module worst_fit_slice_allocator import wfsa_pkg::*; #(
   parameter int FREE_SLOTS = FREE_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   wfsa_req_if.sink              req_ch,
   wfsa_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(FREE_SLOTS + 1);
   localparam int IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int LW = AW + CW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_FIND, S_ALIGN0, S_ALIGN1, S_CHECK, S_REMOVE,
      S_HEAD, S_TAIL, S_PRECHECK, S_MERGE, S_FAPPEND, S_RESULT
   } state_type;

   state_type state_ff;

   logic [FLAGS_W-1:0] chunk_flags_ff;
   logic [PRIO_W-1:0]  chunk_prio_ff;

   logic [CW-1:0] cnt_ff, vis_ff, n_ff;
   logic          op_ff;
   logic [FLAGS_W-1:0] flags_ff;
   logic [PRIO_W-1:0]  prio_ff;
   logic [AW-1:0]  size_ff, align_ff, alm1_ff;
   logic [AW-1:0]  off_ff;
   logic [LW-1:0]  len_ff;
   logic [IW-1:0]  best_ff;
   logic [AW-1:0]  bstart_ff, bsize_ff;
   logic           exact_ff, hit_ff;
   logic [AW:0]    a0_ff, s1_ff;
   logic [AW+2:0]  a1_ff;

   logic [STATUS_W-1:0] pend_status_ff;
   logic [AW-1:0]       pend_off_ff, pend_len_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [AW-1:0]       rsp_off_ff, rsp_len_ff;

   // Slice chain.
   logic [AW-1:0] cs [FREE_SLOTS];
   logic [AW-1:0] cz [FREE_SLOTS];
   cell_ctl_type  ctl;
   logic [IW-1:0] wr_idx;

   genvar g;
   generate
      for (g = 0; g < FREE_SLOTS; g++) begin : g_cell
         if (g < FREE_SLOTS - 1) begin : g_mid
            wfsa_cell #(.IW(IW), .IDX(g)) u_cell (
               .clock(clock), .reset(reset), .ctl(ctl), .wr_idx(wr_idx),
               .nxt_start(cs[g+1]), .nxt_size(cz[g+1]),
               .start(cs[g]), .size(cz[g]));
         end else begin : g_last
            wfsa_cell #(.IW(IW), .IDX(g)) u_cell (
               .clock(clock), .reset(reset), .ctl(ctl), .wr_idx(wr_idx),
               .nxt_start(cs[g]), .nxt_size(cz[g]),
               .start(cs[g]), .size(cz[g]));
         end
      end
   endgenerate

   logic [AW-1:0] head_start, head_size;
   logic [AW:0]   head_end;
   logic [LW-1:0] off_plus_len;
   logic          last_vis;
   logic          hit_right, hit_left;
   logic          csr_size_wr;
   logic [AW-1:0] al_eff;
   logic [AW:0]   a0_calc;
   logic [AW+2:0] a1_calc;
   logic          head_gap, tail_gap;
   logic [CW:0]   need;

   assign head_start = cs[0];
   assign head_size = cz[0];
   assign head_end = {1'b0, head_start} + {1'b0, head_size};
   assign off_plus_len = LW'(off_ff) + len_ff;
   assign last_vis = (vis_ff == n_ff - CW'(1));
   assign hit_right = (LW'(head_start) == off_plus_len);
   assign hit_left = (head_end == {1'b0, off_ff});
   assign csr_size_wr = csr_wr_en && csr_index == CSR_CHUNK_SIZE;
   assign al_eff = (align_ff == '0) ? AW'(1) : align_ff;
   assign a0_calc = ({1'b0, bstart_ff} + {1'b0, al_eff} - (AW+1)'(1))
                    & ~{1'b0, al_eff - AW'(1)};
   assign a1_calc = ((AW+3)'(a0_ff) + (AW+3)'(size_ff) + (AW+3)'(alm1_ff))
                    & ~(AW+3)'(alm1_ff);
   assign head_gap = (a0_ff != {1'b0, bstart_ff});
   assign tail_gap = (a1_ff != (AW+3)'(s1_ff));
   assign need = (CW+1)'(cnt_ff) + (CW+1)'(head_gap) + (CW+1)'(tail_gap);

   // Chain control: passes move the head to the tail unless it is removed or merged.
   always_comb begin
      ctl = '0;
      wr_idx = '0;
      if (csr_size_wr) begin
         ctl.wr_en = 1'b1;
         ctl.wr_start = '0;
         ctl.wr_size = csr_wdata[AW-1:0];
      end else begin
         unique case (state_ff)
            S_FIND, S_PRECHECK: begin
               ctl.shift = 1'b1;
               ctl.wr_en = 1'b1;
               wr_idx = IW'(cnt_ff - CW'(1));
               ctl.wr_start = head_start;
               ctl.wr_size = head_size;
            end
            S_REMOVE: begin
               ctl.shift = 1'b1;
               ctl.wr_en = (vis_ff != CW'(best_ff));
               wr_idx = IW'(cnt_ff - CW'(1));
               ctl.wr_start = head_start;
               ctl.wr_size = head_size;
            end
            S_MERGE: begin
               ctl.shift = 1'b1;
               ctl.wr_en = !(hit_right || hit_left);
               wr_idx = IW'(cnt_ff - CW'(1));
               ctl.wr_start = head_start;
               ctl.wr_size = head_size;
            end
            S_HEAD: begin
               ctl.wr_en = head_gap;
               wr_idx = IW'(cnt_ff);
               ctl.wr_start = bstart_ff;
               ctl.wr_size = a0_ff[AW-1:0] - bstart_ff;
            end
            S_TAIL: begin
               ctl.wr_en = tail_gap;
               wr_idx = IW'(cnt_ff);
               ctl.wr_start = a1_ff[AW-1:0];
               ctl.wr_size = s1_ff[AW-1:0] - a1_ff[AW-1:0];
            end
            S_FAPPEND: begin
               ctl.wr_en = (cnt_ff < CW'(FREE_SLOTS));
               wr_idx = IW'(cnt_ff);
               ctl.wr_start = off_ff;
               ctl.wr_size = len_ff[AW-1:0];
            end
            default: begin
               ctl = '0;
            end
         endcase
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.out_offset = rsp_off_ff;
   assign rsp_ch.out_length = rsp_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= CW'(1);
         chunk_flags_ff <= '0;
         chunk_prio_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CHUNK_SIZE: cnt_ff <= CW'(1);
               CSR_CHUNK_FLAGS: chunk_flags_ff <= csr_wdata[FLAGS_W-1:0];
               CSR_CHUNK_PRIO: chunk_prio_ff <= csr_wdata[PRIO_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff <= req_ch.opcode;
                  flags_ff <= req_ch.req_flags;
                  prio_ff <= req_ch.req_priority;
                  size_ff <= req_ch.req_size;
                  align_ff <= req_ch.req_align;
                  off_ff <= req_ch.rel_offset;
                  len_ff <= LW'(req_ch.rel_length);
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               vis_ff <= '0;
               n_ff <= cnt_ff;
               hit_ff <= 1'b0;
               pend_off_ff <= '0;
               pend_len_ff <= '0;
               if (op_ff == OP_ALLOC) begin
                  if (flags_ff != chunk_flags_ff || prio_ff != chunk_prio_ff) begin
                     pend_status_ff <= ST_MISMATCH;
                     state_ff <= S_RESULT;
                  end else if (cnt_ff == '0) begin
                     pend_status_ff <= ST_EMPTY;
                     state_ff <= S_RESULT;
                  end else begin
                     state_ff <= S_FIND;
                  end
               end else if (cnt_ff >= CW'(FREE_SLOTS)) begin
                  state_ff <= S_PRECHECK;
               end else if (cnt_ff == '0) begin
                  state_ff <= S_FAPPEND;
               end else begin
                  state_ff <= S_MERGE;
               end
            end
            S_FIND: begin
               // First exact size wins; otherwise the first of the largest size.
               if (vis_ff == '0) begin
                  best_ff <= '0;
                  bstart_ff <= head_start;
                  bsize_ff <= head_size;
                  exact_ff <= (head_size == size_ff);
               end else if (!exact_ff &&
                            (head_size == size_ff || head_size > bsize_ff)) begin
                  best_ff <= IW'(vis_ff);
                  bstart_ff <= head_start;
                  bsize_ff <= head_size;
                  exact_ff <= (head_size == size_ff);
               end
               vis_ff <= vis_ff + CW'(1);
               if (last_vis) begin
                  state_ff <= S_ALIGN0;
               end
            end
            S_ALIGN0: begin
               a0_ff <= a0_calc;
               alm1_ff <= al_eff - AW'(1);
               s1_ff <= {1'b0, bstart_ff} + {1'b0, bsize_ff};
               state_ff <= S_ALIGN1;
            end
            S_ALIGN1: begin
               a1_ff <= a1_calc;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               vis_ff <= '0;
               n_ff <= cnt_ff;
               if (a1_ff > (AW+3)'(s1_ff)) begin
                  pend_status_ff <= ST_NO_FIT;
                  state_ff <= S_RESULT;
               end else if (need > (CW+1)'(FREE_SLOTS + 1)) begin
                  pend_status_ff <= ST_OVERFLOW;
                  state_ff <= S_RESULT;
               end else begin
                  state_ff <= S_REMOVE;
               end
            end
            S_REMOVE: begin
               if (vis_ff == CW'(best_ff)) begin
                  cnt_ff <= cnt_ff - CW'(1);
               end
               vis_ff <= vis_ff + CW'(1);
               if (last_vis) begin
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               if (head_gap) begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
               state_ff <= S_TAIL;
            end
            S_TAIL: begin
               if (tail_gap) begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
               pend_status_ff <= ST_OK;
               pend_off_ff <= a0_ff[AW-1:0];
               pend_len_ff <= a1_ff[AW-1:0] - a0_ff[AW-1:0];
               state_ff <= S_RESULT;
            end
            S_PRECHECK: begin
               vis_ff <= vis_ff + CW'(1);
               if (hit_right || hit_left) begin
                  hit_ff <= 1'b1;
               end
               if (last_vis) begin
                  vis_ff <= '0;
                  if (hit_ff || hit_right || hit_left) begin
                     state_ff <= S_MERGE;
                  end else begin
                     pend_status_ff <= ST_OVERFLOW;
                     state_ff <= S_RESULT;
                  end
               end
            end
            S_MERGE: begin
               // The running region grows as neighbors are absorbed.
               if (hit_right) begin
                  len_ff <= len_ff + LW'(head_size);
                  cnt_ff <= cnt_ff - CW'(1);
               end else if (hit_left) begin
                  off_ff <= head_start;
                  len_ff <= len_ff + LW'(head_size);
                  cnt_ff <= cnt_ff - CW'(1);
               end
               vis_ff <= vis_ff + CW'(1);
               if (last_vis) begin
                  state_ff <= S_FAPPEND;
               end
            end
            S_FAPPEND: begin
               if (cnt_ff < CW'(FREE_SLOTS)) begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
               pend_status_ff <= ST_OK;
               pend_off_ff <= off_ff;
               pend_len_ff <= len_ff[AW-1:0];
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_status_ff <= pend_status_ff;
                  rsp_off_ff <= pend_off_ff;
                  rsp_len_ff <= pend_len_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(FREE_SLOTS))
      else $error("free slice count above capacity");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == S_DISPATCH)
      else $error("accepted word did not start processing");

   a_error_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_off_ff == '0 && rsp_len_ff == '0)
      else $error("failed result carries nonzero fields");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("result appeared outside result state");

   a_remove_drops_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HEAD && $past(state_ff == S_REMOVE) |-> cnt_ff == n_ff - CW'(1))
      else $error("removal pass did not drop exactly one slice");
`endif

endmodule
